>>> design/pkc_pkg.sv
// shared types and constants of the position keeper and risk check
// no dependencies; imported by every module of the block
package pkc_pkg;

  // accumulator width: largest product sum is below 2^73 in magnitude
  localparam int ACC_W = 74;

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_PRICE = 2'd1;
  localparam logic [1:0] CMD_RISK  = 2'd2;

  localparam logic KIND_POS  = 1'b0;
  localparam logic KIND_RISK = 1'b1;

  localparam logic [1:0] CFG_MAX_POS   = 2'd0;
  localparam logic [1:0] CFG_MAX_LOSS  = 2'd1;
  localparam logic [1:0] CFG_DAILY_PNL = 2'd2;

  localparam logic [47:0] MAX_POS_RST  = 48'd1000000000;
  localparam logic [47:0] MAX_LOSS_RST = 48'd50000000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         symbol_index;
    logic               is_fill;
    logic signed [31:0] quantity;
    logic [31:0]        price;
  } req_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         out_symbol;
    logic signed [31:0] position_qty;
    logic signed [39:0] avg_price;
    logic signed [63:0] unrealized;
    logic signed [63:0] pos_value;
    logic               approved;
  } rsp_t;

  // one table row per symbol
  typedef struct packed {
    logic               seen;
    logic               known;
    logic signed [31:0] net;
    logic signed [39:0] ent;
    logic [63:0]        pnl;
    logic [31:0]        last;
  } row_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_NE_LO,
    MUL_NE_HI,
    MUL_CP,
    MUL_MV,
    MUL_DF_LO,
    MUL_DF_HI,
    MUL_RK_LO,
    MUL_RK_HI
  } mul_sel_e;

  typedef struct packed {
    logic     capture;
    logic     rd;
    logic     rd_walk;
    logic     wr;
    logic     wr_walk;
    logic     wr_zero;
    logic     idx_inc;
    logic     idx_clr;
    logic     acc_clr;
    mul_sel_e mul;
    logic     init_pos;
    logic     upd_net;
    logic     upd_ent;
    logic     set_price;
    logic     upd_pnl;
    logic     out_pos;
    logic     out_risk;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       in_table;
    logic       net_zero;
    logic       sum_zero;
    logic       walk_hit;
    logic       div_done;
    logic       idx_last;
    logic       out_free;
  } sts_t;

endpackage

>>> design/pkc_div.sv
// iterative restoring divider, one quotient bit per cycle
// signed dividend of ACC_W bits by signed 32 bit divisor, quotient saturated to 40 bits
// depends on pkc_pkg
module pkc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [pkc_pkg::ACC_W-1:0] dividend,
  input  logic signed [31:0]               divisor,
  output logic                             busy,
  output logic signed [39:0]               quotient
);
  import pkc_pkg::*;

  localparam int N  = ACC_W;
  localparam int CW = $clog2(N);

  logic [CW-1:0] cnt;
  logic [31:0]   rem;
  logic [N-1:0]  dvd;
  logic [31:0]   dvs;
  logic [N-1:0]  quo;
  logic          neg;

  logic [N-1:0]  dvd_u;
  logic [31:0]   dvs_u;
  logic [32:0]   rem_sh;
  logic          ge;
  logic [32:0]   rem_sub;
  logic [31:0]   rem_nx;

  always_comb begin
    dvd_u   = dividend;
    dvs_u   = divisor;
    rem_sh  = {rem, dvd[N-1]};
    ge      = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
    rem_nx  = ge ? rem_sub[31:0] : rem_sh[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dvd_u[N-1] ? (~dvd_u + N'(1)) : dvd_u;
      dvs <= dvs_u[31] ? (~dvs_u + 32'd1) : dvs_u;
      neg <= dvd_u[N-1] ^ dvs_u[31];
      rem <= '0;
      quo <= '0;
      cnt <= CW'(N - 1);
    end else if (busy) begin
      rem <= rem_nx;
      dvd <= {dvd[N-2:0], 1'b0};
      quo <= {quo[N-2:0], ge};
      cnt <= cnt - CW'(1);
    end
  end

  // truncated quotient, saturated to the 40 bit signed range
  always_comb begin
    if (neg) begin
      if ((|quo[N-1:40]) || (quo[39] && (|quo[38:0]))) begin
        quotient = 40'sh80_0000_0000;
      end else begin
        quotient = -$signed(quo[39:0]);
      end
    end else begin
      if (|quo[N-1:39]) begin
        quotient = 40'sh7F_FFFF_FFFF;
      end else begin
        quotient = $signed(quo[39:0]);
      end
    end
  end

endmodule

>>> design/pkc_dp.sv
// datapath: symbol table memory, working row, shared 32x32 multiplier with
// accumulator, divider, limit registers and the result register
// depends on pkc_pkg and pkc_div
module pkc_dp #(
  parameter int SYMBOLS = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  pkc_pkg::req_t req,
  input  pkc_pkg::ctl_t ctl,
  output pkc_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pkc_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [47:0]   cfg_data
);
  import pkc_pkg::*;

  localparam int IW = $clog2(SYMBOLS);

  row_t mem [SYMBOLS];

  req_t               item;
  row_t               wrk;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      sym_addr;
  logic [IW-1:0]      raddr;
  logic [IW-1:0]      waddr;
  logic [47:0]        max_pos;
  logic [47:0]        max_loss;
  logic [47:0]        daily;

  logic signed [31:0] chg;
  logic [31:0]        mag_net;
  logic [31:0]        mag_chg;
  logic [39:0]        mag_ent;
  logic [41:0]        diff;
  logic [41:0]        mag_diff;
  logic [32:0]        rs;
  logic [32:0]        mag_rs;
  logic [32:0]        sum_w;
  logic signed [31:0] sum_sat;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic               mul_neg;
  logic               mul_sh;
  logic [63:0]        prod_q;
  logic               prod_neg;
  logic               prod_sh;
  logic               prod_vld;
  logic [ACC_W-1:0]   ext;
  logic signed [ACC_W-1:0] acc;
  logic [63:0]        acc_sat;

  logic               div_busy;
  logic signed [39:0] div_q;
  logic               proj_fail;
  logic [49:0]        dl;
  logic [49:0]        ml;
  logic               loss_hit;

  assign sym_addr = IW'(item.symbol_index);
  assign raddr    = ctl.rd_walk ? idx : sym_addr;
  assign waddr    = ctl.wr_walk ? idx : sym_addr;

  always_comb begin
    chg      = item.is_fill ? item.quantity : 32'sd0;
    mag_net  = wrk.net[31] ? (~wrk.net + 32'd1) : wrk.net;
    mag_chg  = chg[31] ? (~chg + 32'd1) : chg;
    mag_ent  = wrk.ent[39] ? (~wrk.ent + 40'd1) : wrk.ent;
    diff     = {10'd0, wrk.last} - {{2{wrk.ent[39]}}, wrk.ent};
    mag_diff = diff[41] ? (~diff + 42'd1) : diff;
    rs       = {wrk.net[31], wrk.net} + {item.quantity[31], item.quantity};
    mag_rs   = rs[32] ? (~rs + 33'd1) : rs;
    sum_w    = {wrk.net[31], wrk.net} + {chg[31], chg};
    if (sum_w[32] != sum_w[31]) begin
      sum_sat = sum_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum_w[31:0];
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    mul_sh  = 1'b0;
    case (ctl.mul)
      MUL_NE_LO: begin
        mul_a   = mag_net;
        mul_b   = mag_ent[31:0];
        mul_neg = wrk.net[31] ^ wrk.ent[39];
      end
      MUL_NE_HI: begin
        mul_a   = mag_net;
        mul_b   = {24'd0, mag_ent[39:32]};
        mul_neg = wrk.net[31] ^ wrk.ent[39];
        mul_sh  = 1'b1;
      end
      MUL_CP: begin
        mul_a   = mag_chg;
        mul_b   = item.price;
        mul_neg = chg[31];
      end
      MUL_MV: begin
        mul_a   = mag_net;
        mul_b   = wrk.last;
        mul_neg = wrk.net[31];
      end
      MUL_DF_LO: begin
        mul_a   = mag_net;
        mul_b   = mag_diff[31:0];
        mul_neg = wrk.net[31] ^ diff[41];
      end
      MUL_DF_HI: begin
        mul_a   = mag_net;
        mul_b   = {23'd0, mag_diff[40:32]};
        mul_neg = wrk.net[31] ^ diff[41];
        mul_sh  = 1'b1;
      end
      MUL_RK_LO: begin
        mul_a = mag_rs[31:0];
        mul_b = item.price;
      end
      MUL_RK_HI: begin
        mul_a  = {31'd0, mag_rs[32]};
        mul_b  = item.price;
        mul_sh = 1'b1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= (ctl.mul != MUL_NONE);
    end
  end

  always_ff @(posedge clk) begin
    prod_q   <= mul_a * mul_b;
    prod_neg <= mul_neg;
    prod_sh  <= mul_sh;
  end

  assign ext = prod_sh ? {prod_q[41:0], 32'd0} : {10'd0, prod_q};

  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= prod_neg ? (acc - $signed(ext)) : (acc + $signed(ext));
    end
  end

  always_comb begin
    if ((&acc[ACC_W-1:63]) || !(|acc[ACC_W-1:63])) begin
      acc_sat = acc[63:0];
    end else begin
      acc_sat = acc[ACC_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
  end

  pkc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.upd_net && (sum_sat != 32'sd0)),
    .dividend (acc),
    .divisor  (sum_sat),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctl.idx_clr) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[waddr] <= ctl.wr_zero ? '0 : wrk;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      wrk <= mem[raddr];
    end else begin
      if (ctl.init_pos) begin
        wrk.net  <= chg;
        wrk.ent  <= {8'd0, item.price};
        wrk.seen <= 1'b1;
      end
      if (ctl.upd_net) begin
        wrk.net  <= sum_sat;
        wrk.seen <= 1'b1;
      end
      if (ctl.upd_ent) begin
        wrk.ent <= div_q;
      end
      if (ctl.set_price) begin
        wrk.last  <= item.price;
        wrk.known <= 1'b1;
      end
      if (ctl.upd_pnl) begin
        wrk.pnl <= acc_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pos  <= MAX_POS_RST;
      max_loss <= MAX_LOSS_RST;
      daily    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_POS:   max_pos  <= cfg_data;
        CFG_MAX_LOSS:  max_loss <= cfg_data;
        CFG_DAILY_PNL: daily    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    proj_fail = sts.in_table && wrk.seen && (acc > $signed({26'd0, max_pos}));
    dl        = {{2{daily[47]}}, daily};
    ml        = 50'd0 - {2'd0, max_loss};
    loss_hit  = $signed(dl) < $signed(ml);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_pos || ctl.out_risk) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_pos) begin
      rsp.kind         <= KIND_POS;
      rsp.out_symbol   <= item.symbol_index;
      rsp.position_qty <= wrk.net;
      rsp.avg_price    <= wrk.ent;
      rsp.unrealized   <= wrk.pnl;
      rsp.pos_value    <= wrk.known ? acc[63:0] : 64'sd0;
      rsp.approved     <= 1'b0;
    end else if (ctl.out_risk) begin
      rsp.kind         <= KIND_RISK;
      rsp.out_symbol   <= item.symbol_index;
      rsp.position_qty <= '0;
      rsp.avg_price    <= '0;
      rsp.unrealized   <= '0;
      rsp.pos_value    <= '0;
      rsp.approved     <= !proj_fail && !loss_hit;
    end
  end

  always_comb begin
    sts.cmd      = item.cmd;
    sts.in_table = int'(item.symbol_index) < SYMBOLS;
    sts.net_zero = (wrk.net == 32'sd0);
    sts.sum_zero = (sum_sat == 32'sd0);
    sts.walk_hit = (wrk.net != 32'sd0) && wrk.known;
    sts.div_done = !div_busy;
    sts.idx_last = (idx == IW'(SYMBOLS - 1));
    sts.out_free = !rsp_valid || !rsp_stall;
  end

endmodule

>>> design/pkc_ctrl.sv
// controller: sequences table clearing, fills, price walks and risk checks
// drives datapath commands from a single state machine
// depends on pkc_pkg
module pkc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pkc_pkg::sts_t sts,
  output pkc_pkg::ctl_t ctl
);
  import pkc_pkg::*;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_DEC,
    S_F_RD,
    S_F_CHK,
    S_F_M2,
    S_F_M3,
    S_F_M4,
    S_F_SUM,
    S_F_DIV,
    S_MV,
    S_MV2,
    S_POUT,
    S_P_RD,
    S_P_UPD,
    S_P_WR,
    S_W_RD,
    S_W_CHK,
    S_W_M2,
    S_W_M3,
    S_W_M4,
    S_W_NX,
    S_R_RD,
    S_R_CHK,
    S_R_M2,
    S_R_M3,
    S_ROUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl        = '0;
    ctl.mul    = MUL_NONE;
    state_next = state;
    case (state)
      S_CLR: begin
        ctl.wr      = 1'b1;
        ctl.wr_walk = 1'b1;
        ctl.wr_zero = 1'b1;
        if (sts.idx_last) begin
          ctl.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.cmd == CMD_EXEC && sts.in_table) begin
          state_next = S_F_RD;
        end else if (sts.cmd == CMD_PRICE && sts.in_table) begin
          state_next = S_P_RD;
        end else if (sts.cmd == CMD_RISK) begin
          state_next = S_R_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_F_RD: begin
        ctl.rd     = 1'b1;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (sts.net_zero) begin
          ctl.init_pos = 1'b1;
          state_next   = S_MV;
        end else begin
          ctl.acc_clr = 1'b1;
          ctl.mul     = MUL_NE_LO;
          state_next  = S_F_M2;
        end
      end
      S_F_M2: begin
        ctl.mul    = MUL_NE_HI;
        state_next = S_F_M3;
      end
      S_F_M3: begin
        ctl.mul    = MUL_CP;
        state_next = S_F_M4;
      end
      S_F_M4: begin
        state_next = S_F_SUM;
      end
      S_F_SUM: begin
        ctl.upd_net = 1'b1;
        state_next  = sts.sum_zero ? S_MV : S_F_DIV;
      end
      S_F_DIV: begin
        if (sts.div_done) begin
          ctl.upd_ent = 1'b1;
          state_next  = S_MV;
        end
      end
      S_MV: begin
        ctl.acc_clr = 1'b1;
        ctl.mul     = MUL_MV;
        state_next  = S_MV2;
      end
      S_MV2: begin
        state_next = S_POUT;
      end
      S_POUT: begin
        if (sts.out_free) begin
          ctl.out_pos = 1'b1;
          ctl.wr      = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_P_RD: begin
        ctl.rd     = 1'b1;
        state_next = S_P_UPD;
      end
      S_P_UPD: begin
        ctl.set_price = 1'b1;
        state_next    = S_P_WR;
      end
      S_P_WR: begin
        ctl.wr      = 1'b1;
        ctl.idx_clr = 1'b1;
        state_next  = S_W_RD;
      end
      S_W_RD: begin
        ctl.rd      = 1'b1;
        ctl.rd_walk = 1'b1;
        state_next  = S_W_CHK;
      end
      S_W_CHK: begin
        if (sts.walk_hit) begin
          ctl.acc_clr = 1'b1;
          ctl.mul     = MUL_DF_LO;
          state_next  = S_W_M2;
        end else begin
          state_next = S_W_NX;
        end
      end
      S_W_M2: begin
        ctl.mul    = MUL_DF_HI;
        state_next = S_W_M3;
      end
      S_W_M3: begin
        state_next = S_W_M4;
      end
      S_W_M4: begin
        ctl.upd_pnl = 1'b1;
        state_next  = S_W_NX;
      end
      S_W_NX: begin
        ctl.wr      = 1'b1;
        ctl.wr_walk = 1'b1;
        if (sts.idx_last) begin
          ctl.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          ctl.idx_inc = 1'b1;
          state_next  = S_W_RD;
        end
      end
      S_R_RD: begin
        ctl.rd     = 1'b1;
        state_next = S_R_CHK;
      end
      S_R_CHK: begin
        ctl.acc_clr = 1'b1;
        ctl.mul     = MUL_RK_LO;
        state_next  = S_R_M2;
      end
      S_R_M2: begin
        ctl.mul    = MUL_RK_HI;
        state_next = S_R_M3;
      end
      S_R_M3: begin
        state_next = S_ROUT;
      end
      S_ROUT: begin
        if (sts.out_free) begin
          ctl.out_risk = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

`ifndef SYNTHESIS
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.out_pos || ctl.out_risk) |-> sts.out_free)
    else $error("result word loaded while output register still occupied");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    ctl.upd_ent |-> sts.div_done)
    else $error("average price taken from a busy divider");

  a_risk_ro: assert property (@(posedge clk) disable iff (rst)
    (state == S_R_RD || state == S_R_CHK || state == S_R_M2 ||
     state == S_R_M3 || state == S_ROUT) |-> !ctl.wr)
    else $error("risk check wrote the position table");
`endif

endmodule

>>> design/position_keeper_risk_check.sv
// Per-symbol position keeper with pre-trade risk check.
// Request channel (req_valid/req_stall/req) takes one word per item: execution,
// market price or risk check. Result channel (rsp_valid/rsp_stall/rsp) returns one
// position update per execution within the table and one verdict per risk check;
// price words and unknown commands give nothing. Config channel (cfg_valid/cfg_ready,
// always ready) writes max_position_value, max_daily_loss and daily_pnl by index.
// Items are handled one at a time through a shared 32x32 multiplier, with the
// request channel stalled until the item is done, the result word going valid last:
//   execution   the multiplies on an open position, then, unless the new position
//               is flat, a wait while the bit-serial divider forms the new average
//   risk check  the multiplies of the projected position by the price
//   price       a row update plus a walk over the whole table, multiplying for
//               each open position with a known price
// After reset the table is cleared, one row per cycle, with the request channel
// stalled. Limits take their reset values.
// A finished result sits in the output register; a stalled receiver only holds
// the block once it has the next result ready to load.
// depends on pkc_pkg, pkc_ctrl, pkc_dp
module position_keeper_risk_check #(
  parameter int SYMBOLS = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pkc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pkc_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [47:0]   cfg_data
);
  import pkc_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pkc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  pkc_dp #(
    .SYMBOLS (SYMBOLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
